[hdl/bvam_pkg.sv]
package bvam_pkg;

   localparam int DEF_WINDOW_SAMPLES = 10;
   localparam int DEF_GROUP_SIZE     = 8;
   localparam int DEF_ADC_BITS       = 12;

   localparam int SPAN_MV       = 42900;
   localparam int MV_PER_VOLT   = 1000;
   localparam int BUS_MV_MAX    = 4194303;
   localparam int QUERY_NUM_W   = 34;

   localparam logic [2:0] CSR_FITTED  = 3'd0;
   localparam logic [2:0] CSR_CAL     = 3'd1;
   localparam logic [2:0] CSR_CAL_MIN = 3'd2;
   localparam logic [2:0] CSR_CAL_MAX = 3'd3;
   localparam logic [2:0] CSR_CAL_DEF = 3'd4;
   localparam logic [2:0] CSR_UNDER   = 3'd5;
   localparam logic [2:0] CSR_OVER    = 3'd6;
   localparam logic [2:0] CSR_HYST    = 3'd7;

   localparam logic        OP_CONVERSION = 1'b0;
   localparam logic        OP_QUERY      = 1'b1;

   typedef struct packed {
      logic        op;
      logic [11:0] conversion;
      logic [16:0] meter_mv;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [21:0] bus_mv;
      logic        under_voltage;
      logic        over_voltage;
      logic [11:0] last_conversion;
      logic [15:0] suggested_cal;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic sum_step;
      logic mul_init;
      logic mul_step;
      logic div_load_rd;
      logic div_load_q;
      logic div_step;
      logic mv_set;
      logic clamp;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic fitted;
      logic grp_last;
      logic sum_done;
      logic mv_zero;
      logic rsp_free;
      logic is_query;
   } status_type;

endpackage

[hdl/bus_voltage_average_monitor.sv]
// A conversion that does not close a group, or any conversion while not fitted, gives no
// result. A closing conversion sums the ring, multiplies by span and gain and divides;
// a query then divides again and clamps, unless the reading is zero. The shared shift-subtract
// divider gives one quotient bit per cycle; the gain multiplier has 16 steps. One
// transaction is taken at a time. Reset is synchronous and active high; it restores the
// register defaults and clears the group, the ring fill count and the flags.
module bus_voltage_average_monitor
   import bvam_pkg::*;
#(
   parameter int WINDOW_SAMPLES = DEF_WINDOW_SAMPLES,
   parameter int GROUP_SIZE     = DEF_GROUP_SIZE,
   parameter int ADC_BITS       = DEF_ADC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);

   // The divider is wide enough for both the scaled reading and the calibration
   // numerator, so one unit serves both divisions.
   localparam int RAWMAX = (ADC_BITS >= 12) ? 4095 : ((1 << ADC_BITS) - 1);
   localparam int TW     = $clog2(RAWMAX * GROUP_SIZE * WINDOW_SAMPLES + 1);
   localparam int QW     = TW + 32 - ADC_BITS;
   localparam int DIV_W  = (QW > QUERY_NUM_W) ? QW : QUERY_NUM_W;

   cmd_type    cmd;
   status_type status;

   // The controller sequences summing, multiplying and dividing for each transaction.
   bvam_ctrl #(
      .DIV_W (DIV_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the registers, the sample ring and the arithmetic, and its
   // output register lets a finished result wait while the next transaction is taken.
   bvam_dp #(
      .WINDOW_SAMPLES (WINDOW_SAMPLES),
      .GROUP_SIZE     (GROUP_SIZE),
      .ADC_BITS       (ADC_BITS),
      .DIV_W          (DIV_W)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_payload  (req_payload),
      .rsp_payload  (rsp_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

[hdl/bvam_ctrl.sv]
module bvam_ctrl
   import bvam_pkg::*;
#(
   parameter int DIV_W = 39
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_op,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int CNTW = $clog2(DIV_W);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SUM  = 4'd1;
   localparam logic [3:0] S_MUL1 = 4'd2;
   localparam logic [3:0] S_MULG = 4'd3;
   localparam logic [3:0] S_DIVR = 4'd4;
   localparam logic [3:0] S_DIV1 = 4'd5;
   localparam logic [3:0] S_MV   = 4'd6;
   localparam logic [3:0] S_QMUL = 4'd7;
   localparam logic [3:0] S_DIV2 = 4'd8;
   localparam logic [3:0] S_CLMP = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   logic [3:0]      state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CNTW'(1);
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_op == OP_QUERY || (status.fitted && status.grp_last)) begin
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.sum_done) begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_MULG;
         end
         S_MULG: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == CNTW'(15)) begin
               state_in = S_DIVR;
            end
         end
         S_DIVR: begin
            cmd.div_load_rd = 1'b1;
            cnt_in          = '0;
            state_in        = S_DIV1;
         end
         S_DIV1: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNTW'(DIV_W - 1)) begin
               state_in = S_MV;
            end
         end
         S_MV: begin
            cmd.mv_set = 1'b1;
            state_in   = status.is_query ? S_QMUL : S_OUT;
         end
         S_QMUL: begin
            cnt_in = '0;
            if (status.mv_zero) begin
               state_in = S_OUT;
            end else begin
               cmd.div_load_q = 1'b1;
               state_in       = S_DIV2;
            end
         end
         S_DIV2: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNTW'(DIV_W - 1)) begin
               state_in = S_CLMP;
            end
         end
         S_CLMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[hdl/bvam_dp.sv]
module bvam_dp
   import bvam_pkg::*;
#(
   parameter int WINDOW_SAMPLES = DEF_WINDOW_SAMPLES,
   parameter int GROUP_SIZE     = DEF_GROUP_SIZE,
   parameter int ADC_BITS       = DEF_ADC_BITS,
   parameter int DIV_W          = 39
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_payload,
   output rsp_type     rsp_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data,
   input  cmd_type     cmd,
   output status_type  status
);

   localparam int RAWMAX = (ADC_BITS >= 12) ? 4095 : ((1 << ADC_BITS) - 1);
   localparam int SW     = $clog2(RAWMAX * GROUP_SIZE + 1);
   localparam int TW     = $clog2(RAWMAX * GROUP_SIZE * WINDOW_SAMPLES + 1);
   localparam int NUMW   = TW + 32;
   localparam int IW     = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
   localparam int CW     = $clog2(WINDOW_SAMPLES + 1);
   localparam int GW     = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam int DENMAX = WINDOW_SAMPLES * GROUP_SIZE * MV_PER_VOLT;
   localparam int DSW    = ($clog2(DENMAX + 1) > 22) ? $clog2(DENMAX + 1) : 22;
   localparam logic [11:0]    RAW_MASK = 12'(RAWMAX);
   localparam logic [DSW-1:0] DEN_UNIT = DSW'(GROUP_SIZE * MV_PER_VOLT);

   logic        fitted_ff, fitted_in;
   logic [15:0] cal_ff, cal_in, cal_min_ff, cal_min_in, cal_max_ff, cal_max_in;
   logic [15:0] cal_def_ff, cal_def_in;
   logic [16:0] uth_ff, uth_in, oth_ff, oth_in, hyst_ff, hyst_in;

   logic [SW-1:0] ring_ff [WINDOW_SAMPLES];
   logic          ring_we;
   logic [CW-1:0] filled_ff, filled_in, k_ff, k_in;
   logic [IW-1:0] widx_ff, widx_in;
   logic [GW-1:0] gcnt_ff, gcnt_in;
   logic [SW-1:0] gsum_ff, gsum_in, gsum_next;
   logic [11:0]   raw_ff, raw_in, raw_now;
   logic          under_ff, under_in, over_ff, over_in;

   logic            op_ff, op_in;
   logic [16:0]     meas_ff, meas_in;
   logic [TW-1:0]   total_ff, total_in;
   logic [NUMW-1:0] mcand_ff, mcand_in, acc_ff, acc_in;
   logic [15:0]     gsr_ff, gsr_in;
   logic [DIV_W-1:0] dvd_ff, dvd_in, clamp_v;
   logic [DSW-1:0]  rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DSW:0]    rem_w;
   logic [21:0]     mv_ff, mv_in, mv_val;
   logic [15:0]     sugg_ff, sugg_in, gain;
   logic [QUERY_NUM_W-1:0] qnum;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   assign gain = (cal_ff < cal_min_ff || cal_ff > cal_max_ff) ? cal_def_ff : cal_ff;
   assign raw_now   = req_payload.conversion & RAW_MASK;
   assign gsum_next = gsum_ff + SW'(raw_now);
   assign ring_we   = cmd.accept && req_payload.op == OP_CONVERSION && fitted_ff
                      && status.grp_last;
   assign rem_w     = {rem_ff, dvd_ff[DIV_W-1]};
   assign qnum      = QUERY_NUM_W'(gain) * QUERY_NUM_W'(meas_ff)
                      + QUERY_NUM_W'(mv_ff >> 1);

   always_comb begin
      if (!fitted_ff || filled_ff == '0) begin
         mv_val = '0;
      end else if (dvd_ff > DIV_W'(BUS_MV_MAX)) begin
         mv_val = 22'(BUS_MV_MAX);
      end else begin
         mv_val = dvd_ff[21:0];
      end
      clamp_v = dvd_ff;
      if (clamp_v < DIV_W'(cal_min_ff)) begin
         clamp_v = DIV_W'(cal_min_ff);
      end
      if (clamp_v > DIV_W'(cal_max_ff)) begin
         clamp_v = DIV_W'(cal_max_ff);
      end
   end

   always_comb begin
      status.fitted   = fitted_ff;
      status.grp_last = (gcnt_ff == GW'(GROUP_SIZE - 1));
      status.sum_done = (k_ff == filled_ff);
      status.mv_zero  = (mv_ff == '0);
      status.rsp_free = !rsp_valid_ff || !rsp_stall;
      status.is_query = op_ff;
   end

   always_comb begin
      fitted_in = fitted_ff;
      cal_in     = cal_ff;
      cal_min_in = cal_min_ff;
      cal_max_in = cal_max_ff;
      cal_def_in = cal_def_ff;
      uth_in     = uth_ff;
      oth_in     = oth_ff;
      hyst_in    = hyst_ff;
      filled_in  = filled_ff;
      k_in       = k_ff;
      widx_in    = widx_ff;
      gcnt_in    = gcnt_ff;
      gsum_in    = gsum_ff;
      raw_in     = raw_ff;
      under_in   = under_ff;
      over_in    = over_ff;
      op_in      = op_ff;
      meas_in    = meas_ff;
      total_in   = total_ff;
      mcand_in   = mcand_ff;
      acc_in     = acc_ff;
      gsr_in     = gsr_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      mv_in      = mv_ff;
      sugg_in    = sugg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FITTED:  fitted_in  = csr_data[0];
            CSR_CAL:     cal_in     = csr_data[15:0];
            CSR_CAL_MIN: cal_min_in = csr_data[15:0];
            CSR_CAL_MAX: cal_max_in = csr_data[15:0];
            CSR_CAL_DEF: cal_def_in = csr_data[15:0];
            CSR_UNDER:   uth_in     = csr_data;
            CSR_OVER:    oth_in     = csr_data;
            CSR_HYST:    hyst_in    = csr_data;
            default:     fitted_in  = fitted_ff;
         endcase
      end

      if (cmd.accept) begin
         op_in    = req_payload.op;
         meas_in  = req_payload.meter_mv;
         total_in = '0;
         k_in     = '0;
         if (req_payload.op == OP_CONVERSION && fitted_ff) begin
            raw_in = raw_now;
            if (status.grp_last) begin
               widx_in = (widx_ff == IW'(WINDOW_SAMPLES - 1)) ? '0 : widx_ff + IW'(1);
               if (filled_ff != CW'(WINDOW_SAMPLES)) begin
                  filled_in = filled_ff + CW'(1);
               end
               gsum_in = '0;
               gcnt_in = '0;
            end else begin
               gsum_in = gsum_next;
               gcnt_in = gcnt_ff + GW'(1);
            end
         end
      end

      if (cmd.sum_step && !status.sum_done) begin
         total_in = total_ff + TW'(ring_ff[k_ff[IW-1:0]]);
         k_in     = k_ff + CW'(1);
      end

      if (cmd.mul_init) begin
         mcand_in = NUMW'(total_ff) * NUMW'(SPAN_MV);
         acc_in   = '0;
         gsr_in   = gain;
      end

      if (cmd.mul_step) begin
         if (gsr_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff << 1;
         gsr_in   = gsr_ff >> 1;
      end

      if (cmd.div_load_rd) begin
         dvd_in = DIV_W'(acc_ff >> ADC_BITS);
         dvs_in = DSW'(DSW'(filled_ff) * DEN_UNIT);
         rem_in = '0;
      end

      if (cmd.div_load_q) begin
         dvd_in = DIV_W'(qnum);
         dvs_in = DSW'(mv_ff);
         rem_in = '0;
      end

      if (cmd.div_step) begin
         if (rem_w >= {1'b0, dvs_ff}) begin
            rem_in = DSW'(rem_w - {1'b0, dvs_ff});
            dvd_in = {dvd_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_w[DSW-1:0];
            dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         end
      end

      if (cmd.mv_set) begin
         mv_in   = mv_val;
         sugg_in = '0;
         if (op_ff == OP_CONVERSION) begin
            if (!under_ff && 17'(0) + {1'b0, mv_val} < {1'b0, 17'(0)} + 23'(uth_ff)) begin
               under_in = 1'b1;
            end else if (under_ff && 23'(mv_val) >= 23'(uth_ff) + 23'(hyst_ff)) begin
               under_in = 1'b0;
            end
            if (!over_ff && 23'(mv_val) > 23'(oth_ff)) begin
               over_in = 1'b1;
            end else if (over_ff && 23'(mv_val) + 23'(hyst_ff) <= 23'(oth_ff)) begin
               over_in = 1'b0;
            end
         end
      end

      if (cmd.clamp) begin
         sugg_in = clamp_v[15:0];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in           = 1'b1;
         rsp_in.result_kind     = op_ff;
         rsp_in.bus_mv          = mv_ff;
         rsp_in.under_voltage   = fitted_ff & under_ff;
         rsp_in.over_voltage    = fitted_ff & over_ff;
         rsp_in.last_conversion = raw_ff;
         rsp_in.suggested_cal   = sugg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fitted_ff    <= 1'b1;
         cal_ff       <= 16'd1000;
         cal_min_ff   <= 16'd900;
         cal_max_ff   <= 16'd1100;
         cal_def_ff   <= 16'd1000;
         uth_ff       <= 17'd10000;
         oth_ff       <= 17'd30000;
         hyst_ff      <= 17'd500;
         filled_ff    <= '0;
         widx_ff      <= '0;
         gcnt_ff      <= '0;
         gsum_ff      <= '0;
         raw_ff       <= '0;
         under_ff     <= 1'b0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fitted_ff    <= fitted_in;
         cal_ff       <= cal_in;
         cal_min_ff   <= cal_min_in;
         cal_max_ff   <= cal_max_in;
         cal_def_ff   <= cal_def_in;
         uth_ff       <= uth_in;
         oth_ff       <= oth_in;
         hyst_ff      <= hyst_in;
         filled_ff    <= filled_in;
         widx_ff      <= widx_in;
         gcnt_ff      <= gcnt_in;
         gsum_ff      <= gsum_in;
         raw_ff       <= raw_in;
         under_ff     <= under_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      meas_ff  <= meas_in;
      total_ff <= total_in;
      k_ff     <= k_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      gsr_ff   <= gsr_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      mv_ff    <= mv_in;
      sugg_ff  <= sugg_in;
      rsp_ff   <= rsp_in;
      if (ring_we) begin
         ring_ff[widx_ff] <= gsum_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[tb/tb_bus_voltage_average_monitor.sv]
module tb_bus_voltage_average_monitor;
   import bvam_pkg::*;

   // Clock, reset and the three ports of the monitor.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = CSR_FITTED;
   logic [16:0] csr_data = '0;

   bus_voltage_average_monitor u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The monitor's own copy of its registers and state, kept in step with the DUT.
   logic        m_fitted;
   logic [15:0] m_cal, m_cal_min, m_cal_max, m_cal_def;
   logic [16:0] m_under_th, m_over_th, m_hyst;
   logic [14:0] m_ring [10];
   int unsigned m_filled, m_wr, m_grp_cnt, m_grp_sum;
   logic [11:0] m_latest;
   logic        m_under, m_over;

   // Expected responses in order, and a bookkeeping of mismatches.
   rsp_type     expected_rsps [$];
   int          error_count = 0;
   longint      cycle_count = 0;
   bit          long_hold = 1'b0;
   int          rx_wait = 0;
   bit          rx_took = 1'b0;

   function automatic void reset_monitor_model();
      m_fitted = 1'b1;
      m_cal = 16'd1000; m_cal_min = 16'd900; m_cal_max = 16'd1100; m_cal_def = 16'd1000;
      m_under_th = 17'd10000; m_over_th = 17'd30000; m_hyst = 17'd500;
      for (int k = 0; k < 10; k++) m_ring[k] = '0;
      m_filled = 0; m_wr = 0; m_grp_cnt = 0; m_grp_sum = 0;
      m_latest = '0; m_under = 1'b0; m_over = 1'b0;
   endfunction

   function automatic longint unsigned active_gain();
      if (m_cal < m_cal_min || m_cal > m_cal_max) return longint'(m_cal_def);
      return longint'(m_cal);
   endfunction

   // Averaged calibrated millivolts, saturated to the field's range.
   function automatic longint unsigned averaged_mv();
      longint unsigned total, den, mv;
      total = 0;
      if (!m_fitted || m_filled == 0) return 0;
      for (int k = 0; k < m_filled; k++) total += m_ring[k];
      den = longint'(m_filled) * 8 * 4096 * MV_PER_VOLT;
      mv = (total * SPAN_MV * active_gain()) / den;
      if (mv > BUS_MV_MAX) mv = BUS_MV_MAX;
      return mv;
   endfunction

   // Advances the model by one transaction; returns 1 when a response is due.
   function automatic bit predict_voltage_report(input req_type r, output rsp_type rsp);
      longint unsigned mv, sugg, c;
      sugg = 0;
      if (r.op == OP_CONVERSION) begin
         if (!m_fitted) return 1'b0;
         m_latest = r.conversion;
         m_grp_sum += r.conversion;
         m_grp_cnt++;
         if (m_grp_cnt < 8) return 1'b0;
         m_ring[m_wr] = m_grp_sum[14:0];
         m_wr = (m_wr + 1) % 10;
         if (m_filled < 10) m_filled++;
         m_grp_sum = 0; m_grp_cnt = 0;
         mv = averaged_mv();
         if (!m_under && mv < m_under_th) m_under = 1'b1;
         else if (m_under && mv >= longint'(m_under_th) + m_hyst) m_under = 1'b0;
         if (!m_over && mv > m_over_th) m_over = 1'b1;
         else if (m_over && mv + m_hyst <= m_over_th) m_over = 1'b0;
      end else begin
         mv = averaged_mv();
         if (mv != 0) begin
            c = (active_gain() * r.meter_mv + mv / 2) / mv;
            if (c < m_cal_min) c = m_cal_min;
            if (c > m_cal_max) c = m_cal_max;
            sugg = c;
         end
      end
      rsp.result_kind     = r.op;
      rsp.bus_mv          = mv[21:0];
      rsp.under_voltage   = m_fitted & m_under;
      rsp.over_voltage    = m_fitted & m_over;
      rsp.last_conversion = m_latest;
      rsp.suggested_cal   = sugg[15:0];
      return 1'b1;
   endfunction

   // Register write, applied to the model at the same edge the DUT takes it.
   task automatic write_csr(input logic [2:0] idx, input logic [16:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= val;
      @(posedge clock);
      case (idx)
         CSR_FITTED:  m_fitted   = val[0];
         CSR_CAL:     m_cal      = val[15:0];
         CSR_CAL_MIN: m_cal_min  = val[15:0];
         CSR_CAL_MAX: m_cal_max  = val[15:0];
         CSR_CAL_DEF: m_cal_def  = val[15:0];
         CSR_UNDER:   m_under_th = val;
         CSR_OVER:    m_over_th  = val;
         default:     m_hyst     = val;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Sends one transaction after a random gap, holding it until accepted.
   // The prediction is made at the accepting edge so that order matches the DUT.
   // Valid stays high after the accepting edge, so a gap of zero sends back to back.
   task automatic send_item(input req_type r, input bit idle_ok);
      rsp_type exp_rsp;
      int gap;
      gap = idle_ok ? $urandom_range(12, 0) : 0;
      if ($urandom_range(3, 0) == 0) gap = 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      if (predict_voltage_report(r, exp_rsp)) expected_rsps.push_back(exp_rsp);
   endtask

   // Drops valid, waits until the DUT has drained, then lets a closing conversion finish.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic req_type make_conv(input logic [11:0] v);
      req_type r;
      r = '0; r.op = OP_CONVERSION; r.conversion = v; r.meter_mv = 17'($urandom);
      return r;
   endfunction

   function automatic req_type make_query(input logic [16:0] v);
      req_type r;
      r = '0; r.op = OP_QUERY; r.meter_mv = v; r.conversion = 12'($urandom);
      return r;
   endfunction

   // Receiver: a random number of stall cycles per transaction, with one long hold-off.
   always @(negedge clock) begin
      if (rx_took) begin
         rx_wait = $urandom_range(12, 0);
         rx_took = 1'b0;
      end
      if (reset) rsp_stall <= 1'b0;
      else if (long_hold) rsp_stall <= 1'b1;
      else if (rsp_valid && rx_wait != 0) begin
         rsp_stall <= 1'b1;
         rx_wait--;
      end else rsp_stall <= 1'b0;
   end

   // Response checker: compares each accepted transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rx_took = 1'b1;
         if (expected_rsps.size() == 0) begin
            $error("unexpected response %h", rsp_payload);
            error_count++;
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_payload.result_kind !== e.result_kind) begin
               $error("result_kind exp %0d got %0d", e.result_kind, rsp_payload.result_kind);
               error_count++;
            end
            if (rsp_payload.bus_mv !== e.bus_mv) begin
               $error("bus_mv exp %0d got %0d", e.bus_mv, rsp_payload.bus_mv);
               error_count++;
            end
            if (rsp_payload.under_voltage !== e.under_voltage) begin
               $error("under_voltage exp %0d got %0d", e.under_voltage,
                      rsp_payload.under_voltage);
               error_count++;
            end
            if (rsp_payload.over_voltage !== e.over_voltage) begin
               $error("over_voltage exp %0d got %0d", e.over_voltage,
                      rsp_payload.over_voltage);
               error_count++;
            end
            if (rsp_payload.last_conversion !== e.last_conversion) begin
               $error("last_conversion exp %0d got %0d", e.last_conversion,
                      rsp_payload.last_conversion);
               error_count++;
            end
            if (rsp_payload.suggested_cal !== e.suggested_cal) begin
               $error("suggested_cal exp %0d got %0d", e.suggested_cal,
                      rsp_payload.suggested_cal);
               error_count++;
            end
         end
      end
   end

   // Watchdog: the slowest run is far below this many cycles.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 1000000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Directed rows. A typed expectation takes the place of the predictor's for that
   // row in the scoreboard; rows without one rely on the predictor alone.
   typedef struct {
      req_type req;
      bit      has_typed;
      rsp_type typed;
   } directed_row;

   directed_row directed_rows [$];

   function automatic void add_row(input req_type r, input bit t, input rsp_type e);
      directed_row d;
      d.req = r; d.has_typed = t; d.typed = e;
      directed_rows.push_back(d);
   endfunction

   // A well-formed group of eight around one random level, with some noise.
   task automatic send_group(input int level, input int spread);
      int v;
      for (int k = 0; k < 8; k++) begin
         v = level + $urandom_range(2 * spread, 0) - spread;
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         send_item(make_conv(12'(v)), 1'b1);
      end
   endtask

   task automatic random_phase(input int groups, input int max_level);
      for (int g = 0; g < groups; g++) begin
         if ($urandom_range(9, 0) == 0) send_item(make_query(17'($urandom)), 1'b1);
         else if ($urandom_range(9, 0) == 0)
            send_item(make_conv(12'($urandom)), 1'b1);
         else send_group($urandom_range(max_level, 0), $urandom_range(40, 0));
      end
   endtask

   rsp_type none;
   rsp_type zero_answer;

   initial begin
      reset_monitor_model();
      none = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: a query before any sample, full-scale and zero groups,
      // queries after data, and the not-fitted cases.
      zero_answer = '0;
      zero_answer.result_kind = OP_QUERY;
      add_row(make_query(17'h1FFFF), 1'b1, zero_answer);
      for (int k = 0; k < 8; k++) add_row(make_conv(12'hFFF), 1'b0, none);
      add_row(make_query(17'd42900), 1'b0, none);
      add_row(make_query(17'd0), 1'b0, none);
      add_row(make_query(17'h1FFFF), 1'b0, none);
      for (int k = 0; k < 8; k++) add_row(make_conv(12'h000), 1'b0, none);
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].req, 1'b1);
         if (directed_rows[i].has_typed && expected_rsps.size() != 0) begin
            expected_rsps[expected_rsps.size() - 1] = directed_rows[i].typed;
         end
      end
      wait_idle();

      // Not fitted: conversions vanish and a query answers with a zero reading, no flags and no suggestion.
      write_csr(CSR_FITTED, 17'd0);
      send_item(make_conv(12'hABC), 1'b1);
      send_item(make_query(17'd12000), 1'b1);
      wait_idle();
      write_csr(CSR_FITTED, 17'd1);

      // Default settings with random content, then a long receiver hold-off
      // while the sender keeps offering transactions.
      random_phase(40, 4095);
      fork
         begin
            long_hold = 1'b1;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         random_phase(4, 4095);
      join
      wait_idle();

      // Extreme calibration: out-of-range value falling back, max-wins clamp,
      // wide thresholds and a hysteresis larger than the over threshold.
      write_csr(CSR_CAL, 17'hFFFF);
      write_csr(CSR_CAL_MIN, 17'd2000);
      write_csr(CSR_CAL_MAX, 17'd500);
      write_csr(CSR_CAL_DEF, 17'hFFFF);
      write_csr(CSR_UNDER, 17'h1FFFF);
      write_csr(CSR_OVER, 17'd100);
      write_csr(CSR_HYST, 17'h1FFFF);
      random_phase(40, 4095);
      wait_idle();

      // Zero extremes.
      write_csr(CSR_CAL, 17'd0);
      write_csr(CSR_CAL_MIN, 17'd0);
      write_csr(CSR_CAL_MAX, 17'hFFFF);
      write_csr(CSR_UNDER, 17'd0);
      write_csr(CSR_OVER, 17'd0);
      write_csr(CSR_HYST, 17'd0);
      random_phase(30, 4095);
      wait_idle();

      // Thresholds near the working range so the flags toggle often.
      write_csr(CSR_CAL, 17'd1000);
      write_csr(CSR_CAL_MIN, 17'd900);
      write_csr(CSR_CAL_MAX, 17'd1100);
      write_csr(CSR_CAL_DEF, 17'd1000);
      write_csr(CSR_UNDER, 17'd15000);
      write_csr(CSR_OVER, 17'd25000);
      write_csr(CSR_HYST, 17'd300);
      random_phase(50, 3400);
      wait_idle();

      // Random register settings, fitted toggled now and then.
      for (int p = 0; p < 8; p++) begin
         write_csr(CSR_FITTED, 17'($urandom_range(4, 0) != 0));
         write_csr(CSR_CAL, 17'($urandom_range(1300, 700)));
         write_csr(CSR_CAL_MIN, 17'($urandom_range(1000, 600)));
         write_csr(CSR_CAL_MAX, 17'($urandom_range(1400, 1000)));
         write_csr(CSR_CAL_DEF, 17'($urandom));
         write_csr(CSR_UNDER, 17'($urandom_range(30000, 0)));
         write_csr(CSR_OVER, 17'($urandom_range(45000, 10000)));
         write_csr(CSR_HYST, 17'($urandom_range(3000, 0)));
         random_phase(12, 4095);
         wait_idle();
      end

      wait_idle();
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/bvam_pkg.sv
hdl/bvam_ctrl.sv
hdl/bvam_dp.sv
hdl/bus_voltage_average_monitor.sv
tb/tb_bus_voltage_average_monitor.sv
